### hw/rtl/sofd_pkg.sv
// Shared types and constants of the start-of-frame / length deframer.
// Used by the controller, the datapath and the top level; depends on nothing.
package sofd_pkg;

  // Field widths
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned LEN_W    = 7;
  localparam int unsigned CMD_W    = 16;
  localparam int unsigned IDX_W    = 6;
  localparam int unsigned TRL_W    = 16;
  localparam int unsigned CFG_IX_W = 2;
  localparam int unsigned CFG_D_W  = 16;
  localparam int unsigned OUT_D_W  = 48;

  // Configuration register indexes
  localparam logic [CFG_IX_W-1:0] CFG_START_BYTE = 2'd0;
  localparam logic [CFG_IX_W-1:0] CFG_EXP_LENGTH = 2'd1;
  localparam logic [CFG_IX_W-1:0] CFG_ACC_CMD    = 2'd2;

  // Register reset values
  localparam logic [BYTE_W-1:0] START_BYTE_RST = 8'hA5;
  localparam logic [LEN_W-1:0]  EXP_LENGTH_RST = 7'd64;
  localparam logic [CMD_W-1:0]  ACC_CMD_RST    = 16'h0001;

  // Controller to datapath commands
  typedef struct packed {
    logic ld_len_lo;
    logic ld_len_hi;
    logic ld_seq;
    logic ld_hchk;
    logic ld_cmd_lo;
    logic clr_count;
    logic wr_payload;
    logic ld_trl_lo;
    logic ld_trl_hi;
    logic rd_issue;
  } sofd_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic start_hit;
    logic len_ok;
    logic cmd_ok;
    logic data_last;
    logic rd_slot;
    logic rd_last;
  } sofd_sts_t;

endpackage

### hw/rtl/sofd_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module sofd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                 clk,
  input  logic                                 wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                     wr_data,
  input  logic                                 rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                     rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### hw/rtl/sofd_ctrl.sv
// Frame parsing controller: walks the header, payload and trailer fields and
// sequences the payload read-out. Depends on sofd_pkg.
module sofd_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  sofd_pkg::sofd_sts_t sts,
  output sofd_pkg::sofd_cmd_t cmd
);
  import sofd_pkg::*;

  localparam logic [3:0] ST_HUNT   = 4'd0;
  localparam logic [3:0] ST_LEN_LO = 4'd1;
  localparam logic [3:0] ST_LEN_HI = 4'd2;
  localparam logic [3:0] ST_SEQ    = 4'd3;
  localparam logic [3:0] ST_HCHK   = 4'd4;
  localparam logic [3:0] ST_CMD_LO = 4'd5;
  localparam logic [3:0] ST_CMD_HI = 4'd6;
  localparam logic [3:0] ST_DATA   = 4'd7;
  localparam logic [3:0] ST_TRL_LO = 4'd8;
  localparam logic [3:0] ST_TRL_HI = 4'd9;
  localparam logic [3:0] ST_EMIT   = 4'd10;

  logic [3:0] state_r;
  logic [3:0] state_nxt;
  logic       in_fire;

  // Hold off input beats while the payload is read out
  assign in_tready = (state_r != ST_EMIT);
  assign in_fire   = in_tvalid && in_tready;

  // Next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_HUNT: begin
        if (in_fire && sts.start_hit) begin
          state_nxt = ST_LEN_LO;
        end
      end
      ST_LEN_LO: begin
        if (in_fire) begin
          cmd.ld_len_lo = 1'b1;
          state_nxt     = ST_LEN_HI;
        end
      end
      ST_LEN_HI: begin
        if (in_fire) begin
          cmd.ld_len_hi = 1'b1;
          state_nxt     = sts.len_ok ? ST_SEQ : ST_HUNT;
        end
      end
      ST_SEQ: begin
        if (in_fire) begin
          cmd.ld_seq = 1'b1;
          state_nxt  = ST_HCHK;
        end
      end
      ST_HCHK: begin
        if (in_fire) begin
          cmd.ld_hchk = 1'b1;
          state_nxt   = ST_CMD_LO;
        end
      end
      ST_CMD_LO: begin
        if (in_fire) begin
          cmd.ld_cmd_lo = 1'b1;
          state_nxt     = ST_CMD_HI;
        end
      end
      ST_CMD_HI: begin
        if (in_fire) begin
          cmd.clr_count = 1'b1;
          state_nxt     = sts.cmd_ok ? ST_DATA : ST_HUNT;
        end
      end
      ST_DATA: begin
        if (in_fire) begin
          cmd.wr_payload = 1'b1;
          if (sts.data_last) begin
            state_nxt = ST_TRL_LO;
          end
        end
      end
      ST_TRL_LO: begin
        if (in_fire) begin
          cmd.ld_trl_lo = 1'b1;
          state_nxt     = ST_TRL_HI;
        end
      end
      ST_TRL_HI: begin
        if (in_fire) begin
          cmd.ld_trl_hi = 1'b1;
          state_nxt     = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts.rd_slot) begin
          cmd.rd_issue = 1'b1;
          if (sts.rd_last) begin
            state_nxt = ST_HUNT;
          end
        end
      end
      default: begin
        state_nxt = ST_HUNT;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_HUNT;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTHESIS
  // Read-out only starts after the high trailer byte
  a_emit_entry: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r == ST_EMIT) |-> $past(state_r == ST_TRL_HI))
    else $error("read-out entered without trailer");

  // Payload writes and reads never overlap
  a_rd_only_emit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_issue |-> (state_r == ST_EMIT) && !cmd.wr_payload)
    else $error("read issued outside read-out");

  // State stays within the defined codes
  a_state_legal: assert property (@(posedge clk) disable iff (!rst_n)
    state_r <= ST_EMIT)
    else $error("illegal controller state");
`endif

endmodule

### hw/rtl/sofd_dp.sv
// Deframer datapath: configuration registers, header holding registers,
// payload store and the output register. Depends on sofd_pkg and sofd_ram.
module sofd_dp #(
  parameter int unsigned MAX_PAYLOAD = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  input  logic [sofd_pkg::CFG_IX_W-1:0]   cfg_index,
  input  logic [sofd_pkg::CFG_D_W-1:0]    cfg_data,
  input  logic [sofd_pkg::BYTE_W-1:0]     rx_byte,
  input  sofd_pkg::sofd_cmd_t             cmd,
  output sofd_pkg::sofd_sts_t             sts,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [sofd_pkg::OUT_D_W-1:0]    out_tdata,
  output logic                            out_tlast
);
  import sofd_pkg::*;

  localparam int unsigned AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PAYLOAD);

  logic [BYTE_W-1:0] start_byte_r;
  logic [LEN_W-1:0]  exp_len_r;
  logic [CMD_W-1:0]  acc_cmd_r;
  logic [BYTE_W-1:0] len_lo_r;
  logic [LEN_W-1:0]  length_r;
  logic [BYTE_W-1:0] seq_r;
  logic [BYTE_W-1:0] hchk_r;
  logic [BYTE_W-1:0] cmd_lo_r;
  logic [BYTE_W-1:0] trl_lo_r;
  logic [TRL_W-1:0]  trl_r;
  logic [LEN_W-1:0]  count_r;
  logic [LEN_W-1:0]  count_inc;
  logic [LEN_W-1:0]  rd_idx_r;
  logic              rd_pend_r;
  logic [IDX_W-1:0]  pend_idx_r;
  logic              pend_last_r;
  logic [BYTE_W-1:0] ram_rd_data;
  logic              out_valid_r;
  logic              out_free;
  logic [BYTE_W-1:0] out_byte_r;
  logic [IDX_W-1:0]  out_idx_r;
  logic              out_last_r;
  logic [BYTE_W-1:0] out_seq_r;
  logic [BYTE_W-1:0] out_hchk_r;
  logic [TRL_W-1:0]  out_trl_r;
  logic [15:0]       len_word;

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r <= START_BYTE_RST;
      exp_len_r    <= EXP_LENGTH_RST;
      acc_cmd_r    <= ACC_CMD_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_START_BYTE: start_byte_r <= cfg_data[BYTE_W-1:0];
        CFG_EXP_LENGTH: exp_len_r    <= cfg_data[LEN_W-1:0];
        CFG_ACC_CMD:    acc_cmd_r    <= cfg_data[CMD_W-1:0];
        default: ;
      endcase
    end
  end

  // Compare the current byte against the configuration
  assign len_word      = {rx_byte, len_lo_r};
  assign count_inc     = count_r + LEN_W'(1);
  assign sts.start_hit = (rx_byte == start_byte_r);
  assign sts.len_ok    = (len_word == {9'd0, exp_len_r}) && (exp_len_r != '0) &&
                         (exp_len_r <= MAX_LEN);
  assign sts.cmd_ok    = ({rx_byte, cmd_lo_r} == acc_cmd_r);
  assign sts.data_last = (count_inc >= length_r);
  assign out_free      = !out_valid_r || out_tready;
  assign sts.rd_slot   = !rd_pend_r && out_free;
  assign sts.rd_last   = (rd_idx_r == length_r - LEN_W'(1));

  // Header, count and trailer registers
  always_ff @(posedge clk) begin
    if (cmd.ld_len_lo) begin
      len_lo_r <= rx_byte;
    end
    if (cmd.ld_len_hi) begin
      length_r <= len_word[LEN_W-1:0];
    end
    if (cmd.ld_seq) begin
      seq_r <= rx_byte;
    end
    if (cmd.ld_hchk) begin
      hchk_r <= rx_byte;
    end
    if (cmd.ld_cmd_lo) begin
      cmd_lo_r <= rx_byte;
    end
    if (cmd.ld_trl_lo) begin
      trl_lo_r <= rx_byte;
    end
    if (cmd.ld_trl_hi) begin
      trl_r <= {rx_byte, trl_lo_r};
    end
  end

  // Payload write counter and read-out index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      rd_idx_r <= '0;
    end else begin
      if (cmd.clr_count) begin
        count_r <= '0;
      end else if (cmd.wr_payload) begin
        count_r <= count_inc;
      end
      if (cmd.ld_trl_hi) begin
        rd_idx_r <= '0;
      end else if (cmd.rd_issue) begin
        rd_idx_r <= rd_idx_r + LEN_W'(1);
      end
    end
  end

  sofd_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAX_PAYLOAD)
  ) u_store (
    .clk     (clk),
    .wr_en   (cmd.wr_payload),
    .wr_addr (count_r[AW-1:0]),
    .wr_data (rx_byte),
    .rd_en   (cmd.rd_issue),
    .rd_addr (rd_idx_r[AW-1:0]),
    .rd_data (ram_rd_data)
  );

  // Track the read in flight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pend_r <= 1'b0;
    end else begin
      rd_pend_r <= cmd.rd_issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_issue) begin
      pend_idx_r  <= rd_idx_r[IDX_W-1:0];
      pend_last_r <= sts.rd_last;
    end
  end

  // Output register, loaded as read data returns
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rd_pend_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Hold the frame header and trailer with the beat, as the next frame may
  // overwrite them while this beat waits
  always_ff @(posedge clk) begin
    if (rd_pend_r) begin
      out_byte_r <= ram_rd_data;
      out_idx_r  <= pend_idx_r;
      out_last_r <= pend_last_r;
      out_seq_r  <= seq_r;
      out_hchk_r <= hchk_r;
      out_trl_r  <= trl_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {2'b00, out_trl_r, out_hchk_r, out_seq_r, out_idx_r, out_byte_r};

`ifndef SYNTHESIS
  // Returning read data always finds the output register free
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> out_free)
    else $error("read data overran a waiting result");

  // Payload writes stay inside the announced length
  a_wr_in_len: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_payload |-> (count_r < length_r) && (length_r <= MAX_LEN))
    else $error("payload write beyond length");

  // A waiting result beat holds still
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |=> out_valid_r && $stable(out_tdata) && $stable(out_tlast))
    else $error("waiting result beat changed");
`endif

endmodule

### hw/rtl/sof_length_frame_deframer_core.sv
// Start-of-frame / length / command deframer, top level.
// Takes one input beat per cycle while parsing a frame. After the high trailer
// byte of an accepted frame the input stalls while the stored payload is read
// out: a new read is issued only once the data of the previous read has
// passed the registered RAM read into the single output register and that
// register is free, so output back-pressure lengthens the stall. Input is
// taken again as soon as the last read is issued; the last beat then passes
// the RAM read register and the output register. Check bytes are passed
// through unverified. Depends on sofd_pkg, sofd_ctrl, sofd_dp and sofd_ram.
module sof_length_frame_deframer_core #(
  parameter int unsigned MAX_PAYLOAD = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Configuration write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sofd_pkg::CFG_IX_W-1:0] cfg_index,
  input  logic [sofd_pkg::CFG_D_W-1:0]  cfg_data,
  // Received byte stream
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [sofd_pkg::BYTE_W-1:0]   in_tdata,   // [7:0] rx_byte
  // Payload result stream
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [7:0] payload_byte, [13:8] byte_index, [21:14] sequence_number,
  // [29:22] header_check, [45:30] trailer_check, [47:46] zero
  output logic [sofd_pkg::OUT_D_W-1:0]  out_tdata,
  output logic                          out_tlast   // last_of_frame
);
  import sofd_pkg::*;

  sofd_cmd_t cmd;
  sofd_sts_t sts;

  // Register writes are always taken
  assign cfg_ready = 1'b1;

  sofd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sofd_dp #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .rx_byte    (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
